[src/tlv_stream_parser_core_assert.svh]
// Assertion macros used by the parser source tsp_parser.sv.
`ifndef TLV_STREAM_PARSER_CORE_ASSERT_SVH
`define TLV_STREAM_PARSER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define TSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define TSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/tsp_pkg.sv]
package tsp_pkg;

  localparam int unsigned HdrLen = 6;
  localparam int unsigned SigLen = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegMagic   = 2'd0;
  localparam logic [1:0] RegVersion = 2'd1;
  localparam logic [1:0] RegLength  = 2'd2;
  localparam logic [1:0] RegEndian  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindHdr   = 2'd1;
  localparam logic [1:0] KindValue = 2'd2;
  localparam logic [1:0] KindError = 2'd3;

  // Error codes.
  localparam logic [2:0] ErrShortSig = 3'd0;
  localparam logic [2:0] ErrBadId    = 3'd1;
  localparam logic [2:0] ErrBadVer   = 3'd2;
  localparam logic [2:0] ErrShortHdr = 3'd3;
  localparam logic [2:0] ErrTypeZero = 3'd4;
  localparam logic [2:0] ErrOverlong = 3'd5;

  // Input actions.
  localparam logic ActStart = 1'b0;
  localparam logic ActData  = 1'b1;

  typedef struct packed {
    logic [23:0] magic_identity;
    logic [7:0]  format_version;
    logic [31:0] input_length;
    logic        little_endian;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] packet_type;
    logic        critical;
    logic [31:0] value_length;
    logic [7:0]  value_byte;
    logic        last_of_packet;
    logic        end_of_input;
    logic [2:0]  error_code;
  } result_t;

endpackage

[src/tsp_apb_regs.sv]
module tsp_apb_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output tsp_pkg::cfg_t    cfg_o
);
  import tsp_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        RegMagic:   cfg_d.magic_identity = pwdata[23:0];
        RegVersion: cfg_d.format_version = pwdata[7:0];
        RegLength:  cfg_d.input_length   = pwdata;
        RegEndian:  cfg_d.little_endian  = pwdata[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegMagic:   prdata = {8'd0, cfg_q.magic_identity};
      RegVersion: prdata = {24'd0, cfg_q.format_version};
      RegLength:  prdata = cfg_q.input_length;
      RegEndian:  prdata = {31'd0, cfg_q.little_endian};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[src/tsp_in_stage.sv]
module tsp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tsp_pkg::item_t  item_i,
  output logic            vld_o,
  output tsp_pkg::item_t  item_o,
  input  logic            take_i
);
  import tsp_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;
  logic  load;

  assign in_ready_o = ~vld_q | take_i;
  assign load       = in_valid_i & in_ready_o;
  assign vld_o      = vld_q;
  assign item_o     = item_q;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // The word itself needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

[src/tsp_parser.sv]
module tsp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tsp_pkg::cfg_t    cfg_i,
  input  logic             vld_i,
  input  tsp_pkg::item_t   item_i,
  output logic             take_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tsp_pkg::result_t res_o
);
  import tsp_pkg::*;

  `include "tlv_stream_parser_core_assert.svh"

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhSig  = 3'd1;
  localparam logic [2:0] PhHdr  = 3'd2;
  localparam logic [2:0] PhVal  = 3'd3;
  localparam logic [2:0] PhErr  = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [39:0] hdr_q, hdr_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [31:0] vrem_q, vrem_d;
  logic        id_ok_q, id_ok_d;
  logic        out_vld_q, out_vld_d;
  result_t     res_q, res_d;
  logic        have_res;

  logic [31:0] pos_inc, left0, left1, len_m1, n_val, vrem_dec;
  logic [15:0] t_val;
  logic [47:0] hdr_full;
  logic [7:0]  b, exp_byte;
  logic        eoi, id_ok_new;

  assign take_o      = vld_i & (~out_vld_q | out_ready_i);
  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

  assign b        = item_i.data_byte;
  assign pos_inc  = pos_q + 32'd1;
  assign len_m1   = cfg_i.input_length - 32'd1;
  assign left0    = (pos_q < cfg_i.input_length) ? (cfg_i.input_length - pos_q) : 32'd0;
  assign left1    = (pos_inc < cfg_i.input_length) ? (cfg_i.input_length - pos_inc) : 32'd0;
  assign eoi      = (cfg_i.input_length != 32'd0) && (pos_q == len_m1);
  assign hdr_full = {hdr_q, b};
  assign vrem_dec = vrem_q - 32'd1;

  // Signature byte expected at this position, byte zero in the top bits.
  always_comb begin
    unique case (pos_q[1:0])
      2'd0:    exp_byte = cfg_i.magic_identity[23:16];
      2'd1:    exp_byte = cfg_i.magic_identity[15:8];
      2'd2:    exp_byte = cfg_i.magic_identity[7:0];
      default: exp_byte = cfg_i.format_version;
    endcase
  end
  assign id_ok_new = id_ok_q & (b == exp_byte);

  always_comb begin
    if (cfg_i.little_endian) begin
      t_val = {hdr_full[39:32], hdr_full[47:40]};
      n_val = {hdr_full[7:0], hdr_full[15:8], hdr_full[23:16], hdr_full[31:24]};
    end else begin
      t_val = hdr_full[47:32];
      n_val = hdr_full[31:0];
    end
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    hdr_d    = hdr_q;
    hcnt_d   = hcnt_q;
    vrem_d   = vrem_q;
    id_ok_d  = id_ok_q;
    have_res = 1'b0;
    res_d    = '0;

    if (item_i.action == ActStart) begin
      phase_d  = PhSig;
      pos_d    = '0;
      hdr_d    = '0;
      hcnt_d   = '0;
      vrem_d   = '0;
      id_ok_d  = 1'b1;
      have_res = 1'b1;
      if (cfg_i.input_length < 32'(SigLen)) begin
        res_d.kind       = KindError;
        res_d.error_code = ErrShortSig;
        phase_d          = PhErr;
      end else begin
        res_d.kind = KindStart;
      end
    end else begin
      unique case (phase_q)
        PhSig: begin
          pos_d = pos_inc;
          res_d.end_of_input = eoi;
          if (pos_q < 32'd3) begin
            id_ok_d = id_ok_new;
            if (pos_q == 32'd2 && !id_ok_new) begin
              have_res         = 1'b1;
              res_d.kind       = KindError;
              res_d.error_code = ErrBadId;
              phase_d          = PhErr;
            end
          end else if (b != cfg_i.format_version) begin
            have_res         = 1'b1;
            res_d.kind       = KindError;
            res_d.error_code = ErrBadVer;
            phase_d          = PhErr;
          end else begin
            phase_d = PhHdr;
          end
        end
        PhHdr: begin
          if (hcnt_q == '0 && left0 == '0) begin
            // Stream exhausted at a record boundary: drop the byte.
            phase_d = phase_q;
          end else if (hcnt_q == '0 && left0 < 32'(HdrLen)) begin
            pos_d              = pos_inc;
            have_res           = 1'b1;
            res_d.kind         = KindError;
            res_d.error_code   = ErrShortHdr;
            res_d.end_of_input = (left0 == 32'd1);
            phase_d            = PhErr;
          end else begin
            pos_d = pos_inc;
            hdr_d = hdr_full[39:0];
            if (hcnt_q == 3'(HdrLen - 1)) begin
              hcnt_d             = '0;
              have_res           = 1'b1;
              res_d.end_of_input = eoi;
              if (t_val == 16'd0) begin
                res_d.kind       = KindError;
                res_d.error_code = ErrTypeZero;
                phase_d          = PhErr;
              end else if (n_val > left1) begin
                res_d.kind       = KindError;
                res_d.error_code = ErrOverlong;
                phase_d          = PhErr;
              end else begin
                res_d.kind           = KindHdr;
                res_d.packet_type    = t_val[14:0];
                res_d.critical       = t_val[15];
                res_d.value_length   = n_val;
                res_d.last_of_packet = (n_val == 32'd0);
                vrem_d               = n_val;
                phase_d              = (n_val == 32'd0) ? PhHdr : PhVal;
              end
            end else begin
              hcnt_d = hcnt_q + 3'd1;
            end
          end
        end
        PhVal: begin
          pos_d                = pos_inc;
          vrem_d               = vrem_dec;
          have_res             = 1'b1;
          res_d.kind           = KindValue;
          res_d.value_byte     = b;
          res_d.last_of_packet = (vrem_dec == 32'd0);
          res_d.end_of_input   = eoi;
          if (vrem_dec == 32'd0) begin
            phase_d = PhHdr;
          end
        end
        default: begin
          // Idle or latched error: data words are ignored.
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (take_o) begin
      out_vld_d = have_res;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      pos_q     <= '0;
      hdr_q     <= '0;
      hcnt_q    <= '0;
      vrem_q    <= '0;
      id_ok_q   <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (take_o) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        hdr_q   <= hdr_d;
        hcnt_q  <= hcnt_d;
        vrem_q  <= vrem_d;
        id_ok_q <= id_ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && have_res) begin
      res_q <= res_d;
    end
  end

  `TSP_ASSERT(a_err_latches, take_o && have_res && res_d.kind == KindError |=> phase_q == PhErr, "error result did not latch the error phase")
  `TSP_ASSERT(a_val_has_bytes, phase_q == PhVal |-> vrem_q != 32'd0, "value phase with no bytes left")
  `TSP_ASSERT_ALWAYS(a_hcnt_in_hdr, hcnt_q != 3'd0 |-> phase_q == PhHdr, "header count outside header phase")

endmodule

[src/tlv_stream_parser_core.sv]
// Type-length-value stream parser, one byte word per clock, one parse pass per word.
// The accepting edge loads the input register, and the result register is
// loaded when the parser takes the word. Throughput: one word per cycle.
// A full result register stalls the input only while out_ready_i is low.
// Reset (rst_ni low, asynchronous) returns the registers and parse state to their
// reset values, leaves the parser idle until a start word and drops pending words.
module tlv_stream_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // Input channel: one word is a start command or one stream byte.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,

  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [14:0] packet_type_o,
  output logic        critical_o,
  output logic [31:0] value_length_o,
  output logic [7:0]  value_byte_o,
  output logic        last_of_packet_o,
  output logic        end_of_input_o,
  output logic [2:0]  error_code_o
);
  import tsp_pkg::*;

  cfg_t    cfg;
  item_t   in_item, stage_item;
  result_t res;
  logic    stage_vld;
  logic    take;

  assign in_item.action    = action_i;
  assign in_item.data_byte = data_byte_i;

  // Register file. Writes land in the access phase; reads are combinational.
  tsp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register. It refills in the same cycle the parser takes its word,
  // so a full result register only stalls the input when it is not drained.
  tsp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .vld_o      (stage_vld),
    .item_o     (stage_item),
    .take_i     (take)
  );

  // Parse state and result register. Words that produce no result
  // (signature bytes, header bytes, ignored bytes) leave the result
  // register untouched.
  tsp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .vld_i       (stage_vld),
    .item_i      (stage_item),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o           = res.kind;
  assign packet_type_o    = res.packet_type;
  assign critical_o       = res.critical;
  assign value_length_o   = res.value_length;
  assign value_byte_o     = res.value_byte;
  assign last_of_packet_o = res.last_of_packet;
  assign end_of_input_o   = res.end_of_input;
  assign error_code_o     = res.error_code;

endmodule

[tb/tlv_stream_parser_core_tb.sv]
// Testbench for the type-length-value stream parser.
//
// A shadow parser in this module tracks the signature, header and value
// phases of the block word by word. Every word that the block accepts is run
// through it, and any result it produces is queued. A monitor pops the queue
// on each accepted result word and compares every field. Configuration is
// only touched while the parser has nothing in flight, so the shadow copy of
// the registers is updated together with each bus write.
module tlv_stream_parser_core_tb;
  import tsp_pkg::*;

  // Parser phases of the shadow model.
  typedef enum logic [2:0] {PhIdle, PhSig, PhHdr, PhVal, PhErr} parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = ActData;
  logic [7:0]  data_byte_i = '0;

  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [14:0] packet_type_o;
  logic        critical_o;
  logic [31:0] value_length_o;
  logic [7:0]  value_byte_o;
  logic        last_of_packet_o;
  logic        end_of_input_o;
  logic [2:0]  error_code_o;

  tlv_stream_parser_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .packet_type_o    (packet_type_o),
    .critical_o       (critical_o),
    .value_length_o   (value_length_o),
    .value_byte_o     (value_byte_o),
    .last_of_packet_o (last_of_packet_o),
    .end_of_input_o   (end_of_input_o),
    .error_code_o     (error_code_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the registers and of the parse state.
  cfg_t         shadow_cfg = '0;
  parse_phase_e parser_phase = PhIdle;
  logic [31:0]  stream_pos = '0;
  logic [47:0]  header_shift = '0;
  logic [31:0]  value_left = '0;
  int unsigned  header_fill = 0;
  logic         identity_match = 1'b1;

  // Results that the block still owes, oldest first.
  result_t      expected_results[$];
  result_t      head_result;
  int           mismatch_count = 0;
  // Words that the parser acts on; words it drops do not count here.
  int           parsed_words = 0;
  // Random idling on both channels is enabled while this is set.
  bit           idle_enable = 1'b1;
  int           stall_left = 0;
  // Bytes of the stream under construction.
  logic [7:0]   stream_bytes[$];

  function automatic logic [31:0] bytes_left();
    return (stream_pos < shadow_cfg.input_length) ?
           shadow_cfg.input_length - stream_pos : '0;
  endfunction

  // An error is reported once; the parser then drops words until a start.
  function automatic void flag_error(inout result_t r, input logic [2:0] code,
                                     input logic eoi);
    r.kind         = KindError;
    r.end_of_input = eoi;
    r.error_code   = code;
    parser_phase   = PhErr;
  endfunction

  // Advances the shadow parser by one accepted word. Returns 1 when the word
  // yields a result, which is then left in r.
  function automatic bit predict_parse(input logic act, input logic [7:0] b,
                                       output result_t r);
    logic [31:0] left;
    logic [31:0] at;
    logic [7:0]  id_byte;
    logic [15:0] raw_type;
    logic [31:0] len;
    logic        eoi;
    r = '0;
    if (act == ActStart) begin
      parsed_words++;
      parser_phase   = PhSig;
      stream_pos     = '0;
      value_left     = '0;
      header_fill    = 0;
      header_shift   = '0;
      identity_match = 1'b1;
      // Too short to hold a signature: the start itself is the error.
      if (shadow_cfg.input_length < SigLen) flag_error(r, ErrShortSig, 1'b0);
      else r.kind = KindStart;
      return 1'b1;
    end
    if (parser_phase == PhIdle || parser_phase == PhErr) return 1'b0;
    left = bytes_left();
    // At a record boundary past the end of the stream, bytes are dropped.
    if (parser_phase == PhHdr && header_fill == 0 && left == 0) return 1'b0;
    parsed_words++;
    // A header that cannot fit fails on its first byte.
    if (parser_phase == PhHdr && header_fill == 0 && left < HdrLen) begin
      stream_pos = stream_pos + 1;
      flag_error(r, ErrShortHdr, left == 1);
      return 1'b1;
    end
    at = stream_pos;
    stream_pos = stream_pos + 1;
    eoi = (shadow_cfg.input_length != 0) && (at == shadow_cfg.input_length - 1);

    case (parser_phase)
      PhSig: begin
        if (at < 3) begin
          // Identity bytes are compared one by one, judged on the third.
          id_byte = 8'(shadow_cfg.magic_identity >> (16 - 8 * at));
          if (b != id_byte) identity_match = 1'b0;
          if (at == 2 && !identity_match) begin
            flag_error(r, ErrBadId, eoi);
            return 1'b1;
          end
          return 1'b0;
        end
        if (b != shadow_cfg.format_version) begin
          flag_error(r, ErrBadVer, eoi);
          return 1'b1;
        end
        parser_phase = PhHdr;
        return 1'b0;
      end
      PhHdr: begin
        header_shift = {header_shift[39:0], b};
        header_fill++;
        if (header_fill < HdrLen) return 1'b0;
        header_fill = 0;
        if (shadow_cfg.little_endian) begin
          raw_type = {header_shift[39:32], header_shift[47:40]};
          len = {header_shift[7:0], header_shift[15:8], header_shift[23:16],
                 header_shift[31:24]};
        end else begin
          raw_type = header_shift[47:32];
          len = header_shift[31:0];
        end
        // Type zero wins over an overlong length.
        if (raw_type == 16'h0000) begin
          flag_error(r, ErrTypeZero, eoi);
          return 1'b1;
        end
        if (len > bytes_left()) begin
          flag_error(r, ErrOverlong, eoi);
          return 1'b1;
        end
        r.kind           = KindHdr;
        r.packet_type    = raw_type[14:0];
        r.critical       = raw_type[15];
        r.value_length   = len;
        r.last_of_packet = (len == 0);
        r.end_of_input   = eoi;
        value_left       = len;
        parser_phase     = (len == 0) ? PhHdr : PhVal;
        return 1'b1;
      end
      default: begin
        value_left       = value_left - 1;
        r.kind           = KindValue;
        r.value_byte     = b;
        r.last_of_packet = (value_left == 0);
        r.end_of_input   = eoi;
        if (value_left == 0) parser_phase = PhHdr;
        return 1'b1;
      end
    endcase
  endfunction

  // Sends one word and, once the block has taken it, queues its result.
  // The task returns at the accepting edge, so valid is only touched again
  // at the following falling edge.
  task automatic send_word(input logic act, input logic [7:0] b);
    result_t res;
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_parse(act, b, res)) expected_results.push_back(res);
  endtask

  // Two-phase bus write; the shadow register follows at the same time.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegMagic:   shadow_cfg.magic_identity = value[23:0];
      RegVersion: shadow_cfg.format_version = value[7:0];
      RegLength:  shadow_cfg.input_length   = value;
      default:    shadow_cfg.little_endian  = value[0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drops valid and waits until every owed result has been taken. Words
  // without a result may still be in the two-stage pipe at that point, so the
  // task lets the pipe drain before it returns.
  task automatic wait_until_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [23:0] magic, input logic [7:0] version,
                           input logic [31:0] total, input logic le);
    write_reg(RegMagic, {8'h00, magic});
    write_reg(RegVersion, {24'h0, version});
    write_reg(RegLength, total);
    write_reg(RegEndian, {31'h0, le});
  endtask

  function automatic void push_header(input logic le, input logic [15:0] t,
                                      input logic [31:0] n);
    if (le) begin
      stream_bytes.push_back(t[7:0]);
      stream_bytes.push_back(t[15:8]);
      stream_bytes.push_back(n[7:0]);
      stream_bytes.push_back(n[15:8]);
      stream_bytes.push_back(n[23:16]);
      stream_bytes.push_back(n[31:24]);
    end else begin
      stream_bytes.push_back(t[15:8]);
      stream_bytes.push_back(t[7:0]);
      stream_bytes.push_back(n[31:24]);
      stream_bytes.push_back(n[23:16]);
      stream_bytes.push_back(n[15:8]);
      stream_bytes.push_back(n[7:0]);
    end
  endfunction

  // Builds one stream, mostly well formed, and pushes it through the block.
  // A minority of streams is damaged on purpose: a wrong signature byte, a
  // type of zero, a length that runs past the stream, a declared total that
  // is too short, extra bytes within the total, bytes past the end, a stream
  // cut off by the next start, or a huge declared total with a huge record.
  task automatic run_stream();
    logic [23:0] magic;
    logic [7:0]  version;
    logic        le;
    logic [15:0] t;
    logic [31:0] n;
    logic [31:0] total;
    int          nrec;
    int          flavor;
    int          cut;
    int          send_count;
    stream_bytes.delete();
    case ($urandom_range(0, 3))
      0:       magic = 24'h000000;
      1:       magic = 24'hFFFFFF;
      default: magic = 24'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       version = 8'h00;
      1:       version = 8'hFF;
      default: version = 8'($urandom);
    endcase
    le     = 1'($urandom_range(0, 1));
    nrec   = $urandom_range(0, 4);
    flavor = $urandom_range(0, 19);
    stream_bytes.push_back(magic[23:16]);
    stream_bytes.push_back(magic[15:8]);
    stream_bytes.push_back(magic[7:0]);
    stream_bytes.push_back(version);

    for (int r = 0; r < nrec; r++) begin
      case ($urandom_range(0, 6))
        0:       t = 16'h8000;
        1:       t = 16'h7FFF;
        2:       t = 16'hFFFF;
        3:       t = 16'h0001;
        default: t = 16'($urandom);
      endcase
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      if (flavor == 13 && r == 0) t = 16'h0000;
      // The last record claims a few bytes more than the stream holds.
      if (flavor == 14 && r == nrec - 1) push_header(le, t, n + $urandom_range(1, 5));
      else push_header(le, t, n);
      for (int i = 0; i < n; i++) stream_bytes.push_back(8'($urandom));
    end

    total = stream_bytes.size();
    send_count = stream_bytes.size();
    case (flavor)
      12: begin
        cut = $urandom_range(0, 3);
        stream_bytes[cut] = stream_bytes[cut] ^ 8'($urandom_range(1, 255));
      end
      15: begin
        cut = $urandom_range(1, 8);
        total = (cut > total) ? 32'h0 : total - cut;
      end
      16: begin
        cut = $urandom_range(1, 8);
        total = total + cut;
        repeat (cut) stream_bytes.push_back(8'($urandom));
        send_count = stream_bytes.size();
      end
      17: begin
        repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom));
        send_count = stream_bytes.size();
      end
      18: send_count = $urandom_range(1, stream_bytes.size());
      19: begin
        total = 32'hFFFF_FFFF;
        n = 32'hF000_0000 | $urandom_range(0, 32'h0FFF_FFFF);
        push_header(le, 16'h8000 | 16'($urandom_range(1, 16'h7FFF)), n);
        repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom));
        send_count = stream_bytes.size();
      end
      default: ;
    endcase

    configure(magic, version, total, le);
    send_word(ActStart, 8'($urandom));
    for (int i = 0; i < send_count; i++) send_word(ActData, stream_bytes[i]);
    // Occasional stray words, which may restart the stream.
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) send_word(1'($urandom_range(0, 1)), 8'($urandom));
    wait_until_idle();
  endtask

  task automatic test_bytes_before_start();
    send_word(ActData, 8'hFF);
    send_word(ActData, 8'h00);
    wait_until_idle();
  endtask

  // Totals of 0 and 3 bytes fail at the start; later bytes are dropped.
  task automatic test_short_signature();
    configure(24'h000000, 8'h00, 32'd0, 1'b0);
    send_word(ActStart, 8'h00);
    send_word(ActData, 8'hA5);
    wait_until_idle();
    write_reg(RegLength, 32'd3);
    send_word(ActStart, 8'hFF);
    wait_until_idle();
  endtask

  // One wrong identity byte in the middle is only reported on the third.
  task automatic test_bad_identity();
    configure(24'hFFFFFF, 8'h00, 32'd4, 1'b1);
    send_word(ActStart, 8'h00);
    send_word(ActData, 8'hFF);
    send_word(ActData, 8'h7F);
    send_word(ActData, 8'hFF);
    wait_until_idle();
  endtask

  // Wrong version on the very last byte of the stream.
  task automatic test_bad_version();
    send_word(ActStart, 8'h00);
    send_word(ActData, 8'hFF);
    send_word(ActData, 8'hFF);
    send_word(ActData, 8'hFF);
    send_word(ActData, 8'h80);
    wait_until_idle();
  endtask

  // Five bytes left after the signature cannot hold a header.
  task automatic test_short_header();
    write_reg(RegLength, 32'd9);
    send_word(ActStart, 8'h00);
    send_word(ActData, 8'hFF);
    send_word(ActData, 8'hFF);
    send_word(ActData, 8'hFF);
    send_word(ActData, 8'h00);
    send_word(ActData, 8'h12);
    send_word(ActData, 8'h34);
    wait_until_idle();
  endtask

  task automatic test_random_streams(input int target);
    while (parsed_words < target) run_stream();
  endtask

  // Ready stalls come in random bursts, started only while idling is enabled.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Each result word taken from the block is matched against the oldest
  // expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, got kind %0d",
                 $time, kind_o);
        mismatch_count++;
      end else begin
        head_result = expected_results.pop_front();
        check_field("kind", head_result.kind, kind_o);
        check_field("packet_type", head_result.packet_type, packet_type_o);
        check_field("critical", head_result.critical, critical_o);
        check_field("value_length", head_result.value_length, value_length_o);
        check_field("value_byte", head_result.value_byte, value_byte_o);
        check_field("last_of_packet", head_result.last_of_packet, last_of_packet_o);
        check_field("end_of_input", head_result.end_of_input, end_of_input_o);
        check_field("error_code", head_result.error_code, error_code_o);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_bytes_before_start();
    test_short_signature();
    test_bad_identity();
    test_bad_version();
    test_short_header();
    test_random_streams(620);
    // The closing stretch runs at full rate on both channels.
    idle_enable = 1'b0;
    test_random_streams(830);

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/tsp_pkg.sv
src/tsp_apb_regs.sv
src/tsp_in_stage.sv
src/tsp_parser.sv
src/tlv_stream_parser_core.sv
tb/tlv_stream_parser_core_tb.sv
